// ----- hw/rtl/brd_pkg.sv -----
// Shared types, constants and lookup tables of the BAM record decoder.
`timescale 1ns / 1ps

package brd_pkg;

	// Depth of the queue between the parser and the output sequencer.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] QUAL_OFFSET  = 8'd33;
	localparam logic [7:0] QUAL_MISSING = 8'hFF;
	localparam logic [7:0] STAR_CHAR    = 8'h2A;

	// Parser phases in record order.
	typedef enum logic [3:0] {
		PH_LEN    = 4'd0,
		PH_REFID  = 4'd1,
		PH_POS    = 4'd2,
		PH_BMN    = 4'd3,
		PH_FLAGNC = 4'd4,
		PH_LSEQ   = 4'd5,
		PH_MREF   = 4'd6,
		PH_MPOS   = 4'd7,
		PH_TLEN   = 4'd8,
		PH_NAME   = 4'd9,
		PH_CIGAR  = 4'd10,
		PH_SEQ    = 4'd11,
		PH_QUAL   = 4'd12,
		PH_AUX    = 4'd13
	} phase_t;

	// Tags of the result items.
	typedef enum logic [3:0] {
		KIND_REF_ID   = 4'd0,
		KIND_POS      = 4'd1,
		KIND_MAPQ     = 4'd2,
		KIND_FLAG     = 4'd3,
		KIND_MATE_POS = 4'd4,
		KIND_NAME     = 4'd5,
		KIND_CIGAR    = 4'd6,
		KIND_BASE     = 4'd7,
		KIND_QUAL     = 4'd8,
		KIND_AUX      = 4'd9,
		KIND_END      = 4'd10
	} kind_t;

	// Everything one input byte produces: a main item, a second base and an end item.
	typedef struct packed {
		logic        main_vld;
		kind_t       main_kind;
		logic [32:0] main_value;
		logic [7:0]  main_letter;
		logic        base2_vld;
		logic [7:0]  base2_char;
		logic        end_vld;
	} bundle_t;

	// ASCII letter of a packed base code.
	function automatic logic [7:0] base_char(input logic [3:0] code);
		logic [7:0] c;
		case (code)
			4'd0:    c = "=";
			4'd1:    c = "A";
			4'd2:    c = "C";
			4'd3:    c = "M";
			4'd4:    c = "G";
			4'd5:    c = "R";
			4'd6:    c = "S";
			4'd7:    c = "V";
			4'd8:    c = "T";
			4'd9:    c = "W";
			4'd10:   c = "Y";
			4'd11:   c = "H";
			4'd12:   c = "K";
			4'd13:   c = "D";
			4'd14:   c = "B";
			default: c = "N";
		endcase
		return c;
	endfunction

	// ASCII letter of a CIGAR op code, zero for codes with no meaning.
	function automatic logic [7:0] op_char(input logic [3:0] code);
		logic [7:0] c;
		case (code)
			4'd0:    c = "M";
			4'd1:    c = "I";
			4'd2:    c = "D";
			4'd3:    c = "N";
			4'd4:    c = "S";
			4'd5:    c = "H";
			4'd6:    c = "P";
			4'd7:    c = "=";
			4'd8:    c = "X";
			default: c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

// ----- hw/rtl/brd_front.sv -----
// Record parser: takes one byte per transfer and classifies it into a result bundle.
`timescale 1ns / 1ps

module brd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             q_full,
	output logic             push,
	output brd_pkg::bundle_t push_data
);
	import brd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [1:0]  byte_q, byte_n;
	logic [31:0] acc_q, acc_n;
	logic [31:0] left_q, left_n;
	logic [7:0]  name_len_q, name_len_n;
	logic [15:0] cigar_cnt_q, cigar_cnt_n;
	logic [31:0] seq_len_q, seq_len_n;
	logic [31:0] cnt_q, cnt_n;
	logic        absent_q, absent_n;

	logic        accept;
	logic [31:0] word;
	logic        word_done;
	logic [31:0] left_dec;
	logic [32:0] cnt_inc;
	logic [31:0] seq_total;
	bundle_t     bun;

	// Next section of the record that has any bytes, starting at a given phase.
	function automatic phase_t pick(input phase_t ph, input logic [7:0] nl,
			input logic [15:0] cc, input logic [31:0] sl);
		phase_t r;
		if (ph <= PH_NAME && nl != 8'd0) begin
			r = PH_NAME;
		end else if (ph <= PH_CIGAR && cc != 16'd0) begin
			r = PH_CIGAR;
		end else if (ph <= PH_QUAL && sl != 32'd0) begin
			r = (ph <= PH_SEQ) ? PH_SEQ : PH_QUAL;
		end else begin
			r = PH_AUX;
		end
		return r;
	endfunction

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign word      = acc_q | ({24'd0, data_byte} << {byte_q, 3'b000});
	assign word_done = (byte_q == 2'd3);
	assign left_dec  = left_q - 32'd1;
	assign cnt_inc   = {1'b0, cnt_q} + 33'd1;
	assign seq_total = {1'b0, seq_len_q[31:1]} + {31'd0, seq_len_q[0]};

	// Parse step for the byte at the input.
	always_comb begin
		phase_n     = phase_q;
		byte_n      = byte_q;
		acc_n       = acc_q;
		left_n      = left_q;
		name_len_n  = name_len_q;
		cigar_cnt_n = cigar_cnt_q;
		seq_len_n   = seq_len_q;
		cnt_n       = cnt_q;
		absent_n    = absent_q;
		bun         = '0;

		// Little-endian word assembly, used by the word sections.
		if (word_done) begin
			byte_n = 2'd0;
			acc_n  = 32'd0;
		end else begin
			byte_n = byte_q + 2'd1;
			acc_n  = word;
		end

		if (phase_q != PH_LEN) begin
			left_n = left_dec;
		end

		case (phase_q)
			PH_LEN: begin
				if (word_done) begin
					left_n      = word;
					name_len_n  = 8'd0;
					cigar_cnt_n = 16'd0;
					seq_len_n   = 32'd0;
					absent_n    = 1'b0;
					cnt_n       = 32'd0;
					if (word == 32'd0) begin
						bun.end_vld = 1'b1;
						phase_n     = PH_LEN;
					end else begin
						phase_n = PH_REFID;
					end
				end
			end
			PH_REFID, PH_POS, PH_BMN, PH_FLAGNC, PH_LSEQ, PH_MREF, PH_MPOS, PH_TLEN: begin
				if (word_done) begin
					case (phase_q)
						PH_REFID: begin
							bun.main_vld   = 1'b1;
							bun.main_kind  = KIND_REF_ID;
							bun.main_value = {word[31], word};
						end
						PH_POS: begin
							bun.main_vld   = 1'b1;
							bun.main_kind  = KIND_POS;
							bun.main_value = {word[31], word} + 33'd1;
						end
						PH_BMN: begin
							name_len_n     = word[7:0];
							bun.main_vld   = 1'b1;
							bun.main_kind  = KIND_MAPQ;
							bun.main_value = {25'd0, word[15:8]};
						end
						PH_FLAGNC: begin
							cigar_cnt_n    = word[15:0];
							bun.main_vld   = 1'b1;
							bun.main_kind  = KIND_FLAG;
							bun.main_value = {17'd0, word[31:16]};
						end
						PH_LSEQ: begin
							seq_len_n = word;
						end
						PH_MPOS: begin
							bun.main_vld   = 1'b1;
							bun.main_kind  = KIND_MATE_POS;
							bun.main_value = {word[31], word} + 33'd1;
						end
						default: begin
						end
					endcase
					if (phase_q == PH_TLEN) begin
						phase_n = pick(PH_NAME, name_len_q, cigar_cnt_q, seq_len_q);
						cnt_n   = 32'd0;
					end else begin
						phase_n = phase_t'(phase_q + 4'd1);
					end
				end
			end
			PH_NAME: begin
				bun.main_vld   = 1'b1;
				bun.main_kind  = KIND_NAME;
				bun.main_value = {25'd0, data_byte};
				byte_n         = byte_q;
				acc_n          = acc_q;
				cnt_n          = cnt_inc[31:0];
				if (cnt_inc >= {25'd0, name_len_q}) begin
					phase_n = pick(PH_CIGAR, name_len_q, cigar_cnt_q, seq_len_q);
					cnt_n   = 32'd0;
				end
			end
			PH_CIGAR: begin
				if (word_done) begin
					bun.main_vld    = 1'b1;
					bun.main_kind   = KIND_CIGAR;
					bun.main_value  = {5'd0, word[31:4]};
					bun.main_letter = op_char(word[3:0]);
					cnt_n           = cnt_inc[31:0];
					if (cnt_inc >= {17'd0, cigar_cnt_q}) begin
						phase_n = pick(PH_SEQ, name_len_q, cigar_cnt_q, seq_len_q);
						cnt_n   = 32'd0;
					end
				end
			end
			PH_SEQ: begin
				bun.main_vld   = 1'b1;
				bun.main_kind  = KIND_BASE;
				bun.main_value = {25'd0, base_char(data_byte[7:4])};
				bun.base2_vld  = ({cnt_q, 1'b1} < {1'b0, seq_len_q});
				bun.base2_char = base_char(data_byte[3:0]);
				byte_n         = byte_q;
				acc_n          = acc_q;
				cnt_n          = cnt_inc[31:0];
				if (cnt_inc >= {1'b0, seq_total}) begin
					phase_n = pick(PH_QUAL, name_len_q, cigar_cnt_q, seq_len_q);
					cnt_n   = 32'd0;
				end
			end
			PH_QUAL: begin
				byte_n = byte_q;
				acc_n  = acc_q;
				if (cnt_q == 32'd0 && data_byte == QUAL_MISSING) begin
					absent_n       = 1'b1;
					bun.main_vld   = 1'b1;
					bun.main_kind  = KIND_QUAL;
					bun.main_value = {25'd0, STAR_CHAR};
				end else if (!absent_q) begin
					bun.main_vld   = 1'b1;
					bun.main_kind  = KIND_QUAL;
					bun.main_value = {25'd0, data_byte + QUAL_OFFSET};
				end
				cnt_n = cnt_inc[31:0];
				if (cnt_inc >= {1'b0, seq_len_q}) begin
					phase_n = PH_AUX;
					cnt_n   = 32'd0;
				end
			end
			default: begin
				byte_n         = byte_q;
				acc_n          = acc_q;
				bun.main_vld   = 1'b1;
				bun.main_kind  = KIND_AUX;
				bun.main_value = {25'd0, data_byte};
			end
		endcase

		// The last byte of a record closes it, whatever section it falls in.
		if (phase_q != PH_LEN && left_dec == 32'd0) begin
			bun.end_vld = 1'b1;
			phase_n     = PH_LEN;
			cnt_n       = 32'd0;
			byte_n      = 2'd0;
			acc_n       = 32'd0;
		end
	end

	assign push      = accept && (bun.main_vld || bun.base2_vld || bun.end_vld);
	assign push_data = bun;

	// Parser state advances on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			byte_q      <= 2'd0;
			acc_q       <= 32'd0;
			left_q      <= 32'd0;
			name_len_q  <= 8'd0;
			cigar_cnt_q <= 16'd0;
			seq_len_q   <= 32'd0;
			cnt_q       <= 32'd0;
			absent_q    <= 1'b0;
		end else if (accept) begin
			phase_q     <= phase_n;
			byte_q      <= byte_n;
			acc_q       <= acc_n;
			left_q      <= left_n;
			name_len_q  <= name_len_n;
			cigar_cnt_q <= cigar_cnt_n;
			seq_len_q   <= seq_len_n;
			cnt_q       <= cnt_n;
			absent_q    <= absent_n;
		end
	end

	// Inside a record the byte count never sits at zero.
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_LEN) |-> (left_q != 32'd0))
		else $error("record byte count is zero inside a record");

endmodule

// ----- hw/rtl/brd_queue.sv -----
// Short queue of result bundles between the parser and the output sequencer.
`timescale 1ns / 1ps

module brd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  brd_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output brd_pkg::bundle_t head
);
	import brd_pkg::*;

	bundle_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from an empty queue");

endmodule

// ----- hw/rtl/brd_back.sv -----
// Output sequencer: expands each bundle into result items, one transfer per cycle while the receiver does not stall.
`timescale 1ns / 1ps

module brd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  brd_pkg::bundle_t   head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         item_kind,
	output logic signed [32:0] item_value,
	output logic [7:0]         cigar_letter,
	output logic               last_of_record
);
	import brd_pkg::*;

	logic [2:0]  done_q;
	logic [2:0]  pend;
	logic [2:0]  sel;
	logic        out_free;
	logic        load;
	logic        last;
	logic        valid_q;
	kind_t       kind_q;
	logic [32:0] value_q;
	logic [7:0]  letter_q;
	logic        eor_q;
	kind_t       kind_n;
	logic [32:0] value_n;
	logic [7:0]  letter_n;

	// Items of the head bundle still to go: main, second base, end.
	assign pend     = empty ? 3'b000
		: ({head.end_vld, head.base2_vld, head.main_vld} & ~done_q);
	assign sel      = pend & (~pend + 3'd1);
	assign out_free = !valid_q || !out_stall;
	assign load     = out_free && (pend != 3'b000);
	assign last     = ((pend & ~sel) == 3'b000);
	assign pop      = load && last;

	// Payload of the selected item.
	always_comb begin
		kind_n   = KIND_END;
		value_n  = 33'd0;
		letter_n = 8'd0;
		if (sel[0]) begin
			kind_n   = head.main_kind;
			value_n  = head.main_value;
			letter_n = head.main_letter;
		end else if (sel[1]) begin
			kind_n  = KIND_BASE;
			value_n = {25'd0, head.base2_char};
		end
	end

	// Record of which items of the head bundle went out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 3'b000;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= last ? 3'b000 : (done_q | sel);
			end
			if (out_free) begin
				valid_q <= load;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= kind_n;
			value_q  <= value_n;
			letter_q <= letter_n;
			eor_q    <= sel[2];
		end
	end

	assign out_valid      = valid_q;
	assign item_kind      = kind_q;
	assign item_value     = value_q;
	assign cigar_letter   = letter_q;
	assign last_of_record = eor_q;

	// The record-end flag travels only with an end item.
	a_eor_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && eor_q) |-> (kind_q == KIND_END))
		else $error("record end flag on an item that is not an end item");

endmodule

// ----- hw/rtl/bam_record_decoder_unit.sv -----
// Path: a byte's bundle is written into the four-entry bundle queue between the parser
// and the output sequencer; its items leave through the output register. Throughput: one
// byte per cycle in unless the queue is full; one result item per cycle out unless the
// receiver stalls, so a byte with a second base or a record end gives two or three items.
// Reset: asynchronous; the parser waits for a record length word and the queue and
// output are empty.
`timescale 1ns / 1ps

module bam_record_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         item_kind,
	output logic signed [32:0] item_value,
	output logic [7:0]         cigar_letter,
	output logic               last_of_record
);
	import brd_pkg::*;

	logic    push;
	bundle_t push_data;
	logic    q_full;
	logic    pop;
	logic    q_empty;
	bundle_t head;

	// Parser front end.
	brd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// Bundle queue.
	brd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	// Output sequencer.
	brd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.empty          (q_empty),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.item_kind      (item_kind),
		.item_value     (item_value),
		.cigar_letter   (cigar_letter),
		.last_of_record (last_of_record)
	);

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench of the BAM record decoder unit with its own record decoder model.
`timescale 1ns / 1ps

module testbench;
	import brd_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int RANDOM_BYTES   = 210;
	localparam int GAP_PERCENT    = 17;
	localparam logic [8*16-1:0] BASE_LETTERS = "=ACMGRSVTWYHKDBN";
	localparam logic [8*9-1:0]  OP_LETTERS   = "MIDNSHP=X";

	// One decoded item as it should leave the block.
	typedef struct {
		kind_t       kind;
		logic [32:0] value;
		logic [7:0]  letter;
		logic        last;
	} decoded_item_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         data_byte;
	logic               out_valid;
	logic               out_stall;
	logic [3:0]         item_kind;
	logic signed [32:0] item_value;
	logic [7:0]         cigar_letter;
	logic               last_of_record;

	bam_record_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.item_kind      (item_kind),
		.item_value     (item_value),
		.cigar_letter   (cigar_letter),
		.last_of_record (last_of_record)
	);

	// Decoder state of the model, at its reset values.
	phase_t      cur_phase    = PH_LEN;
	logic [1:0]  word_byte    = '0;
	logic [31:0] word_acc     = '0;
	logic [31:0] bytes_left   = '0;
	logic [7:0]  name_len     = '0;
	logic [15:0] cigar_total  = '0;
	logic [31:0] seq_len      = '0;
	logic [31:0] field_idx    = '0;
	logic        qual_missing = 1'b0;

	decoded_item_t expected_items[$];
	logic [7:0]    record_body[$];
	int            mismatch_count = 0;
	int            bytes_sent     = 0;
	int            hold_left      = 0;
	int            quiet_cycles   = 0;
	bit            no_gaps        = 1'b0;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic push_result(input kind_t kind, input logic [32:0] value,
			input logic [7:0] letter, input logic last);
		decoded_item_t it;
		it.kind   = kind;
		it.value  = value;
		it.letter = letter;
		it.last   = last;
		expected_items.push_back(it);
	endtask

	task automatic enter_phase(input phase_t ph);
		cur_phase = ph;
		field_idx = '0;
		word_byte = '0;
		word_acc  = '0;
	endtask

	// First section, starting at 'from', that holds any data.
	function automatic phase_t next_section(input phase_t from);
		if (from <= PH_NAME && name_len != 0) return PH_NAME;
		if (from <= PH_CIGAR && cigar_total != 0) return PH_CIGAR;
		if (from <= PH_SEQ && seq_len != 0) return PH_SEQ;
		if (from <= PH_QUAL && seq_len != 0) return PH_QUAL;
		return PH_AUX;
	endfunction

	// Collects little-endian bytes; done is set when a word is complete.
	task automatic gather_byte(input logic [7:0] b, output logic done);
		word_acc  = word_acc | ({24'd0, b} << (8 * word_byte));
		done      = (word_byte == 2'd3);
		word_byte = word_byte + 2'd1;
	endtask

	// Updates the model with one transferred byte and queues the items it causes.
	task automatic decode_byte(input logic [7:0] b);
		logic        done;
		logic [31:0] w;
		logic [3:0]  op;
		logic [7:0]  qchar;
		logic [63:0] total;
		int          hi;
		int          lo;
		if (cur_phase == PH_LEN) begin
			gather_byte(b, done);
			if (done) begin
				bytes_left   = word_acc;
				name_len     = '0;
				cigar_total  = '0;
				seq_len      = '0;
				qual_missing = 1'b0;
				enter_phase(PH_REFID);
				if (bytes_left == 0) begin
					push_result(KIND_END, '0, '0, 1'b1);
					enter_phase(PH_LEN);
				end
			end
		end else begin
			bytes_left = bytes_left - 1;
			if (cur_phase <= PH_TLEN) begin
				// Fixed 32-bit fields of the record.
				gather_byte(b, done);
				if (done) begin
					w = word_acc;
					word_acc = '0;
					case (cur_phase)
						PH_REFID:  push_result(KIND_REF_ID, {w[31], w}, '0, 1'b0);
						PH_POS:    push_result(KIND_POS, {w[31], w} + 33'd1, '0, 1'b0);
						PH_BMN: begin
							name_len = w[7:0];
							push_result(KIND_MAPQ, {25'd0, w[15:8]}, '0, 1'b0);
						end
						PH_FLAGNC: begin
							cigar_total = w[15:0];
							push_result(KIND_FLAG, {17'd0, w[31:16]}, '0, 1'b0);
						end
						PH_LSEQ:   seq_len = w;
						PH_MPOS:   push_result(KIND_MATE_POS, {w[31], w} + 33'd1, '0, 1'b0);
						default: ;
					endcase
					if (cur_phase == PH_TLEN)
						enter_phase(next_section(PH_NAME));
					else
						cur_phase = phase_t'(cur_phase + 1);
				end
			end else if (cur_phase == PH_NAME) begin
				push_result(KIND_NAME, {25'd0, b}, '0, 1'b0);
				field_idx++;
				if (field_idx >= name_len)
					enter_phase(next_section(PH_CIGAR));
			end else if (cur_phase == PH_CIGAR) begin
				gather_byte(b, done);
				if (done) begin
					w = word_acc;
					word_acc = '0;
					op = w[3:0];
					push_result(KIND_CIGAR, {5'd0, w[31:4]},
						(op < 4'd9) ? OP_LETTERS[8 * (8 - int'(op)) +: 8] : 8'd0, 1'b0);
					field_idx++;
					if (field_idx >= cigar_total)
						enter_phase(next_section(PH_SEQ));
				end
			end else if (cur_phase == PH_SEQ) begin
				// Two bases per byte; the low nybble past an odd length is dropped.
				total = {33'd0, seq_len[31:1]} + seq_len[0];
				hi = int'(b[7:4]);
				lo = int'(b[3:0]);
				push_result(KIND_BASE, {25'd0, BASE_LETTERS[8 * (15 - hi) +: 8]}, '0, 1'b0);
				if (2 * {32'd0, field_idx} + 1 < {32'd0, seq_len})
					push_result(KIND_BASE, {25'd0, BASE_LETTERS[8 * (15 - lo) +: 8]}, '0, 1'b0);
				field_idx++;
				if ({32'd0, field_idx} >= total)
					enter_phase(next_section(PH_QUAL));
			end else if (cur_phase == PH_QUAL) begin
				if (field_idx == 0 && b == QUAL_MISSING) begin
					qual_missing = 1'b1;
					push_result(KIND_QUAL, {25'd0, STAR_CHAR}, '0, 1'b0);
				end else if (!qual_missing) begin
					qchar = b + QUAL_OFFSET;
					push_result(KIND_QUAL, {25'd0, qchar}, '0, 1'b0);
				end
				field_idx++;
				if (field_idx >= seq_len)
					enter_phase(PH_AUX);
			end else begin
				push_result(KIND_AUX, {25'd0, b}, '0, 1'b0);
			end
			if (bytes_left == 0) begin
				push_result(KIND_END, '0, '0, 1'b1);
				enter_phase(PH_LEN);
			end
		end
	endtask

	// Offers one byte, with an occasional gap first, and waits for its transfer.
	task automatic send_byte(input logic [7:0] b);
		if (!no_gaps && $urandom_range(99) < GAP_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		decode_byte(b);
		bytes_sent++;
	endtask

	// Drops valid and waits until every queued item has come out.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_items.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++) record_body.push_back(w[8 * i +: 8]);
	endtask

	task automatic put_header(input logic [31:0] ref_id, input logic [31:0] pos,
			input logic [7:0] mapq, input logic [7:0] nlen, input logic [15:0] flag,
			input logic [15:0] ncig, input logic [31:0] slen, input logic [31:0] mate_pos);
		put_word(ref_id);
		put_word(pos);
		put_word({16'($urandom), mapq, nlen});
		put_word({flag, ncig});
		put_word(slen);
		put_word($urandom);
		put_word(mate_pos);
		put_word($urandom);
	endtask

	// Sends a length word of 'keep' bytes, capped at the built record's size, and that many bytes of it.
	task automatic send_record(input int keep);
		logic [31:0] len;
		len = (keep < record_body.size()) ? keep : record_body.size();
		for (int i = 0; i < 4; i++) send_byte(len[8 * i +: 8]);
		for (int i = 0; i < len; i++) send_byte(record_body[i]);
		record_body.delete();
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Builds a well-formed record with random sizes and content.
	task automatic put_random_record();
		int nlen;
		int ncig;
		int slen;
		nlen = $urandom_range(4);
		ncig = $urandom_range(3);
		slen = $urandom_range(7);
		put_header(pick_word(), pick_word(), $urandom_range(255), nlen,
			$urandom_range(16'hFFFF), ncig, slen, pick_word());
		repeat (nlen) record_body.push_back($urandom_range(255));
		repeat (ncig) put_word($urandom);
		repeat ((slen + 1) / 2) record_body.push_back($urandom_range(255));
		for (int i = 0; i < slen; i++)
			if (i == 0 && $urandom_range(4) == 0)
				record_body.push_back(QUAL_MISSING);
			else
				record_body.push_back($urandom_range(255));
		repeat ($urandom_range(4)) record_body.push_back($urandom_range(255));
	endtask

	// Checks each transferred item against the oldest expected one.
	always @(posedge clk) begin
		decoded_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_items.size() == 0) begin
				report_mismatch($sformatf("unexpected item kind %0d value %h",
					item_kind, item_value));
			end else begin
				want = expected_items.pop_front();
				if (item_kind !== want.kind)
					report_mismatch($sformatf("item_kind %0d, expected %0d",
						item_kind, want.kind));
				if (item_value !== want.value)
					report_mismatch($sformatf("item_value %h, expected %h (kind %0d)",
						item_value, want.value, want.kind));
				if (cigar_letter !== want.letter)
					report_mismatch($sformatf("cigar_letter %h, expected %h (kind %0d)",
						cigar_letter, want.letter, want.kind));
				if (last_of_record !== want.last)
					report_mismatch($sformatf("last_of_record %b, expected %b (kind %0d)",
						last_of_record, want.last, want.kind));
			end
		end
	end

	// Receiver: random stalls, or a long hold-off counted down here.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !no_gaps && ($urandom_range(99) < GAP_PERCENT);
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// A zero length word gives only the end item.
	task automatic test_empty_record();
		send_record(0);
		send_record(0);
	endtask

	// Extreme values in the fixed fields and a one-base read.
	task automatic test_field_extremes();
		put_header(32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'hFF, 8'd1, 16'hFFFF, 16'd0, 32'd1,
			32'hFFFF_FFFF);
		record_body.push_back(8'hFF);
		record_body.push_back(8'hF0);
		record_body.push_back(8'h00);
		record_body.push_back(8'hFF);
		record_body.push_back(8'h00);
		send_record(record_body.size());
		put_header(32'h0000_0000, 32'h8000_0000, 8'h00, 8'd0, 16'h0000, 16'd0, 32'd0,
			32'h7FFF_FFFF);
		record_body.push_back(8'h5A);
		send_record(record_body.size());
	endtask

	// Every CIGAR op code and every base code, with an odd read length.
	task automatic test_ops_and_bases();
		put_header($urandom, $urandom, 8'd60, 8'd2, 16'h0041, 16'd16, 32'd31, $urandom);
		record_body.push_back("A");
		record_body.push_back("B");
		for (int i = 0; i < 16; i++)
			put_word({(i == 0) ? 28'hFFF_FFFF : 28'($urandom), 4'(i)});
		for (int i = 0; i < 16; i++)
			record_body.push_back({4'(i), 4'(15 - i)});
		record_body.push_back(8'h00);
		record_body.push_back(8'hFF);
		record_body.push_back(8'hDE);
		for (int i = 3; i < 31; i++) record_body.push_back($urandom_range(255));
		send_record(record_body.size());
	endtask

	// A leading 0xFF quality byte gives one star; an empty read gives no quality.
	task automatic test_missing_quality();
		put_header($urandom, $urandom, 8'd3, 8'd0, 16'd0, 16'd0, 32'd4, $urandom);
		record_body.push_back(8'h12);
		record_body.push_back(8'h48);
		record_body.push_back(QUAL_MISSING);
		record_body.push_back(8'h10);
		record_body.push_back(8'hFF);
		record_body.push_back(8'h20);
		record_body.push_back(8'h77);
		send_record(record_body.size());
		put_header($urandom, $urandom, 8'd3, 8'd1, 16'd4, 16'd1, 32'd0, $urandom);
		record_body.push_back("r");
		put_word({28'd5, 4'd0});
		record_body.push_back(8'hFF);
		record_body.push_back(8'h33);
		send_record(record_body.size());
	endtask

	// The byte count runs out in the fixed fields, the name, the CIGAR, the bases and the qualities.
	task automatic test_truncated_records();
		int cuts[7] = '{2, 14, 32, 33, 37, 44, 48};
		foreach (cuts[i]) begin
			put_header(pick_word(), pick_word(), $urandom_range(255), 8'd3,
				$urandom_range(16'hFFFF), 16'd2, 32'd5, pick_word());
			repeat (3 + 8 + 3 + 5 + 2) record_body.push_back($urandom_range(255));
			send_record(cuts[i]);
		end
	endtask

	// Mostly well-formed records, some cut short and some noise.
	task automatic test_random_records();
		int start;
		int sel;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			sel = $urandom_range(99);
			if (sel < 65) begin
				put_random_record();
				send_record(record_body.size());
			end else if (sel < 85) begin
				put_random_record();
				send_record($urandom_range(record_body.size()));
			end else begin
				repeat ($urandom_range(12)) record_body.push_back($urandom_range(255));
				send_record(record_body.size());
			end
		end
	endtask

	// The receiver holds off while the sender keeps offering bytes.
	task automatic test_output_hold();
		no_gaps   = 1'b1;
		hold_left = HOLD_CYCLES;
		repeat (2) begin
			put_random_record();
			send_record(record_body.size());
		end
		no_gaps = 1'b0;
	endtask

	// The sender stops until every expected item has arrived.
	task automatic test_drain_pause();
		put_random_record();
		send_record(record_body.size());
		wait_for_results();
		put_random_record();
		send_record(record_body.size());
	endtask

	// A stretch with no gaps on either side.
	task automatic test_full_rate();
		no_gaps = 1'b1;
		repeat (4) begin
			put_random_record();
			send_record(record_body.size());
		end
		no_gaps = 1'b0;
	endtask

	// Reset, then the tests in turn, then the final verdict.
	initial begin
		in_valid  = 1'b0;
		data_byte = 8'd0;
		arst_n    = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_record();
		test_field_extremes();
		test_ops_and_bases();
		test_missing_quality();
		test_truncated_records();
		test_random_records();
		test_output_hold();
		test_drain_pause();
		test_full_rate();
		wait_for_results();
		repeat (10) @(posedge clk);
		if (expected_items.size() != 0)
			report_mismatch($sformatf("%0d items never arrived", expected_items.size()));
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
